FILE: rtl/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, codes and a helper function of the LC-3 instruction step block.
// ----------------------------------------------------------------------------
package lc3_pkg;

	// Memory geometry.
	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;

	// Configuration port.
	localparam int APB_ADDR_W  = 3;
	localparam logic [15:0] START_PC_RESET = 16'h3000;

	// Command codes.
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_WRREG   = 2'd1;
	localparam logic [1:0] CMD_EXEC    = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// Opcodes.
	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LD   = 4'h2;
	localparam logic [3:0] OP_ST   = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDR  = 4'h6;
	localparam logic [3:0] OP_STR  = 4'h7;
	localparam logic [3:0] OP_NOT  = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_STI  = 4'hB;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_LEA  = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	// Trap vectors served inside the block.
	localparam logic [7:0] TRAP_GETC = 8'h20;
	localparam logic [7:0] TRAP_OUT  = 8'h21;
	localparam logic [7:0] TRAP_HALT = 8'h25;

	// Condition codes.
	localparam logic [2:0] CC_POS = 3'b001;
	localparam logic [2:0] CC_ZERO = 3'b010;
	localparam logic [2:0] CC_NEG = 3'b100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_IND,
		ST_DATA,
		ST_CHECK
	} state_t;

	// One request to the single memory port.
	typedef struct packed {
		logic                     we;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [15:0]              wdata;
	} mem_req_t;

	// Condition code of a result word.
	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] c;
		if (v == 16'h0000) begin
			c = CC_ZERO;
		end else if (v[15]) begin
			c = CC_NEG;
		end else begin
			c = CC_POS;
		end
		return c;
	endfunction

endpackage

FILE: rtl/lc3_if.sv
// ----------------------------------------------------------------------------
// lc3_in_if / lc3_out_if
// Valid/ready channels for commands into and results out of the core.
// ----------------------------------------------------------------------------
interface lc3_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] addr;
	logic [15:0] data;
	logic [2:0]  reg_index;
	logic [7:0]  char_in;

	modport source (output valid, cmd, addr, data, reg_index, char_in, input ready);
	modport sink   (input valid, cmd, addr, data, reg_index, char_in, output ready);
endinterface

interface lc3_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] step_value;
	logic [15:0] pc_now;
	logic [2:0]  cond_code;
	logic [7:0]  out_char;
	logic        out_valid;
	logic [7:0]  trap_vector;

	modport source (output valid, step_value, pc_now, cond_code, out_char, out_valid,
		trap_vector, input ready);
	modport sink   (input valid, step_value, pc_now, cond_code, out_char, out_valid,
		trap_vector, output ready);
endinterface

FILE: rtl/lc3_mem.sv
// ----------------------------------------------------------------------------
// lc3_mem
// Single-port main memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module lc3_mem
	import lc3_pkg::*;
(
	input  logic        clk,
	input  mem_req_t    req,
	output logic [15:0] rdata
);

	logic [15:0] mem [MEM_WORDS];

	// Write or read the addressed word.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rdata <= mem[req.addr];
		end
	end

endmodule

FILE: rtl/lc3_core.sv
// ----------------------------------------------------------------------------
// lc3_core
// Command sequencer: register file, PC, condition code and result register.
// ----------------------------------------------------------------------------
module lc3_core
	import lc3_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          busy,
	input  logic [15:0]   start_pc,
	lc3_in_if.sink        req,
	lc3_out_if.source     rsp,
	output mem_req_t      mem_req,
	input  logic [15:0]   mem_rdata
);

	state_t      state_q, state_d;
	logic [15:0] pc_q, pc_d;
	logic [2:0]  cc_q, cc_d;
	logic [15:0] regs_q [8];
	logic [15:0] inst_q;
	logic [7:0]  char_q;

	logic        reg_we;
	logic [2:0]  reg_wa;
	logic [15:0] reg_wd;
	logic        reg7_we;
	logic [15:0] reg7_wd;

	logic        ov_q;
	logic [15:0] step_q, pcnow_q;
	logic [2:0]  ccnow_q;
	logic [7:0]  och_q, tv_q;
	logic        ovld_q;

	logic        push;
	logic [15:0] push_step;
	logic [7:0]  push_och, push_tv;
	logic        push_ovld;
	logic        out_free;
	logic        accept;

	logic [15:0] inst;
	logic [3:0]  op;
	logic [2:0]  dr, sr1;
	logic [15:0] off9, off6, off11, imm5, pc1, opb, res;

	assign out_free  = !ov_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && !busy && out_free;
	assign accept    = req.valid && req.ready;

	// Instruction fields; the fetched word is live in the fetch state only.
	assign inst  = (state_q == ST_FETCH) ? mem_rdata : inst_q;
	assign op    = inst[15:12];
	assign dr    = inst[11:9];
	assign sr1   = inst[8:6];
	assign off9  = {{7{inst[8]}}, inst[8:0]};
	assign off6  = {{10{inst[5]}}, inst[5:0]};
	assign off11 = {{5{inst[10]}}, inst[10:0]};
	assign imm5  = {{11{inst[4]}}, inst[4:0]};
	assign pc1   = pc_q + 16'd1;
	assign opb   = inst[5] ? imm5 : regs_q[inst[2:0]];

	// Next state, register updates, memory requests and the result.
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		cc_d      = cc_q;
		reg_we    = 1'b0;
		reg_wa    = dr;
		reg_wd    = 16'h0000;
		reg7_we   = 1'b0;
		reg7_wd   = pc1;
		mem_req   = '{we: 1'b0, addr: pc_q[MEM_ADDR_BITS-1:0], wdata: 16'h0000};
		push      = 1'b0;
		push_step = 16'h0000;
		push_och  = 8'h00;
		push_tv   = 8'h00;
		push_ovld = 1'b0;
		res       = 16'h0000;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_LOAD: begin
							mem_req = '{we: 1'b1, addr: req.addr[MEM_ADDR_BITS-1:0],
								wdata: req.data};
							push = 1'b1;
						end
						CMD_WRREG: begin
							reg_we = 1'b1;
							reg_wa = req.reg_index;
							reg_wd = req.data;
							push   = 1'b1;
						end
						CMD_RESTART: begin
							pc_d = start_pc;
							push = 1'b1;
						end
						default: begin
							state_d = ST_FETCH;
						end
					endcase
				end
			end
			ST_FETCH: begin
				pc_d    = pc1;
				state_d = ST_IDLE;
				push    = 1'b1;
				case (op)
					OP_ADD, OP_AND: begin
						res    = (op == OP_ADD) ? regs_q[sr1] + opb : regs_q[sr1] & opb;
						reg_we = 1'b1;
						reg_wd = res;
						cc_d   = cc_of(res);
					end
					OP_NOT: begin
						res    = ~regs_q[sr1];
						reg_we = 1'b1;
						reg_wd = res;
						cc_d   = cc_of(res);
					end
					OP_BR: begin
						if ((dr & cc_q) != 3'b000) begin
							pc_d = pc1 + off9;
						end
					end
					OP_JMP: begin
						pc_d = regs_q[sr1];
					end
					OP_JSR: begin
						pc_d    = inst[11] ? pc1 + off11 : regs_q[sr1];
						reg7_we = 1'b1;
					end
					OP_LEA: begin
						reg_we = 1'b1;
						reg_wd = pc1 + off9;
					end
					OP_LD, OP_LDI, OP_STI: begin
						res     = pc1 + off9;
						mem_req = '{we: 1'b0, addr: res[MEM_ADDR_BITS-1:0], wdata: 16'h0000};
						state_d = (op == OP_LD) ? ST_DATA : ST_IND;
						push    = 1'b0;
					end
					OP_LDR: begin
						res     = regs_q[sr1] + off6;
						mem_req = '{we: 1'b0, addr: res[MEM_ADDR_BITS-1:0], wdata: 16'h0000};
						state_d = ST_DATA;
						push    = 1'b0;
					end
					OP_ST, OP_STR: begin
						res     = (op == OP_ST) ? pc1 + off9 : regs_q[sr1] + off6;
						mem_req = '{we: 1'b1, addr: res[MEM_ADDR_BITS-1:0], wdata: regs_q[dr]};
					end
					OP_TRAP: begin
						push_tv = inst[7:0];
						if (inst[7:0] == TRAP_HALT) begin
							pc_d = 16'h0000;
						end else if (inst[7:0] == TRAP_GETC) begin
							reg_we = 1'b1;
							reg_wa = 3'd0;
							reg_wd = {8'h00, char_q};
						end else if (inst[7:0] == TRAP_OUT) begin
							push_och  = regs_q[0][7:0];
							push_ovld = 1'b1;
						end
					end
					default: begin
					end
				endcase
				// A zero word needs a look at the following word.
				if (inst == 16'h0000) begin
					mem_req = '{we: 1'b0, addr: pc1[MEM_ADDR_BITS-1:0], wdata: 16'h0000};
					state_d = ST_CHECK;
					push    = 1'b0;
				end
				push_step = (op == OP_TRAP) ? 16'h0000 : pc_d;
			end
			ST_IND: begin
				if (inst_q[15:12] == OP_LDI) begin
					mem_req = '{we: 1'b0, addr: mem_rdata[MEM_ADDR_BITS-1:0], wdata: 16'h0000};
					state_d = ST_DATA;
				end else begin
					mem_req = '{we: 1'b1, addr: mem_rdata[MEM_ADDR_BITS-1:0],
						wdata: regs_q[dr]};
					state_d   = ST_IDLE;
					push      = 1'b1;
					push_step = pc_q;
				end
			end
			ST_DATA: begin
				reg_we    = 1'b1;
				reg_wd    = mem_rdata;
				cc_d      = cc_of(mem_rdata);
				state_d   = ST_IDLE;
				push      = 1'b1;
				push_step = pc_q;
			end
			ST_CHECK: begin
				state_d   = ST_IDLE;
				push      = 1'b1;
				push_step = (mem_rdata == 16'h0000) ? 16'h0000 : pc_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= START_PC_RESET;
			cc_q    <= 3'b000;
			ov_q    <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 16'h0000;
			end
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			cc_q    <= cc_d;
			ov_q    <= push || (ov_q && !rsp.ready);
			if (reg7_we) begin
				regs_q[7] <= reg7_wd;
			end
			if (reg_we) begin
				regs_q[reg_wa] <= reg_wd;
			end
		end
	end

	// Instruction, keyboard character and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= req.char_in;
		end
		if (state_q == ST_FETCH) begin
			inst_q <= mem_rdata;
		end
		if (push) begin
			step_q  <= push_step;
			pcnow_q <= pc_d;
			ccnow_q <= cc_d;
			och_q   <= push_och;
			ovld_q  <= push_ovld;
			tv_q    <= push_tv;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.step_value  = step_q;
	assign rsp.pc_now      = pcnow_q;
	assign rsp.cond_code   = ccnow_q;
	assign rsp.out_char    = och_q;
	assign rsp.out_valid   = ovld_q;
	assign rsp.trap_vector = tv_q;

endmodule

FILE: rtl/lc3_instruction_step.sv
// ----------------------------------------------------------------------------
// lc3_instruction_step
// LC-3 core taking one command per transaction and returning one result.
// ----------------------------------------------------------------------------
// Load, register write and restart are done in the accept cycle; an execute
// step goes through the single memory port in order: fetch, an optional
// indirect read, and an optional data read or a look at the next word.
// A command is taken only while the result register is empty or being read
// in the same cycle, so back-to-back commands need a ready result side.
// After reset a clearing pass writes zeros to all 2^16 memory words, one per
// cycle, before the first command is accepted.
module lc3_instruction_step
	import lc3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	lc3_in_if.sink                req,
	lc3_out_if.source             rsp
);

	logic [15:0]              start_pc_q;
	logic                     clearing_q;
	logic [MEM_ADDR_BITS-1:0] clr_cnt_q;
	mem_req_t                 core_req, mem_req;
	logic [15:0]              mem_rdata;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == 1'b0) ? {16'h0000, start_pc_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= START_PC_RESET;
		end else if (psel && penable && pwrite && (paddr[APB_ADDR_W-1] == 1'b0)) begin
			start_pc_q <= pwdata[15:0];
		end
	end

	// Memory clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {MEM_ADDR_BITS{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign mem_req = clearing_q ? mem_req_t'{we: 1'b1, addr: clr_cnt_q, wdata: 16'h0000}
		: core_req;

	lc3_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	lc3_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.busy      (clearing_q),
		.start_pc  (start_pc_q),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (core_req),
		.mem_rdata (mem_rdata)
	);

endmodule

FILE: bench/tb_lc3_instruction_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lc3_instruction_step
// Self-checking bench for the LC-3 step core. A directed program touches
// every opcode and the GETC and OUT traps. Random programs are then loaded
// at varying restart addresses and executed. Both channels idle at random,
// and each transaction result is compared field by field against an LC-3
// instruction predictor.
// ----------------------------------------------------------------------------
module tb_lc3_instruction_step;
	import lc3_pkg::*;

	localparam logic [APB_ADDR_W-1:0] REG_START_PC = '0;
	localparam int IDLE_LIMIT = 300000;
	localparam int ITEM_GOAL  = 900;

	typedef struct {
		logic [15:0] step_value;
		logic [15:0] pc_now;
		logic [2:0]  cond_code;
		logic [7:0]  out_char;
		logic        out_valid;
		logic [7:0]  trap_vector;
	} step_result_t;

	// Instruction predictor and the queue of results it expects.
	class step_scoreboard;
		logic [15:0]  mem [MEM_WORDS];
		logic [15:0]  gpr [8];
		logic [15:0]  pc;
		logic [2:0]   cc;
		logic [15:0]  restart_pc;
		step_result_t pending_q [$];
		int           errors;

		function new();
			foreach (mem[i]) mem[i] = 16'h0000;
			foreach (gpr[i]) gpr[i] = 16'h0000;
			restart_pc = START_PC_RESET;
			pc = START_PC_RESET;
			cc = 3'b000;
			errors = 0;
		endfunction

		function logic [15:0] rd(input logic [15:0] a);
			return mem[a & (MEM_WORDS - 1)];
		endfunction

		function void wr(input logic [15:0] a, input logic [15:0] v);
			mem[a & (MEM_WORDS - 1)] = v;
		endfunction

		function void flags(input logic [15:0] v);
			cc = (v == 16'h0000) ? CC_ZERO : (v[15] ? CC_NEG : CC_POS);
		endfunction

		// Work out the result of one accepted command.
		function void note_command(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [15:0] data, input logic [2:0] ri, input logic [7:0] ch);
			step_result_t r;
			logic [15:0] inst, off9, off6, b, a, link;
			logic [2:0]  dr, sr1;
			logic        trapped;
			r = '{default: '0};
			trapped = 1'b0;
			case (cmd)
				CMD_LOAD: wr(addr, data);
				CMD_WRREG: gpr[ri] = data;
				CMD_RESTART: pc = restart_pc;
				default: begin
					inst = rd(pc);
					dr = inst[11:9];
					sr1 = inst[8:6];
					off9 = {{7{inst[8]}}, inst[8:0]};
					off6 = {{10{inst[5]}}, inst[5:0]};
					pc = pc + 16'd1;
					case (inst[15:12])
						OP_ADD, OP_AND: begin
							b = inst[5] ? {{11{inst[4]}}, inst[4:0]} : gpr[inst[2:0]];
							gpr[dr] = (inst[15:12] == OP_ADD) ? gpr[sr1] + b : gpr[sr1] & b;
							flags(gpr[dr]);
						end
						OP_BR: if ((dr & cc) != 3'b000) pc = pc + off9;
						OP_JMP: pc = gpr[sr1];
						OP_JSR: begin
							link = pc;
							pc = inst[11] ? pc + {{5{inst[10]}}, inst[10:0]} : gpr[sr1];
							gpr[7] = link;
						end
						OP_LD: begin
							gpr[dr] = rd(pc + off9);
							flags(gpr[dr]);
						end
						OP_LDI: begin
							a = rd(pc + off9);
							gpr[dr] = rd(a);
							flags(gpr[dr]);
						end
						OP_LDR: begin
							gpr[dr] = rd(gpr[sr1] + off6);
							flags(gpr[dr]);
						end
						OP_LEA: gpr[dr] = pc + off9;
						OP_NOT: begin
							gpr[dr] = ~gpr[sr1];
							flags(gpr[dr]);
						end
						OP_ST: wr(pc + off9, gpr[dr]);
						OP_STI: begin
							a = rd(pc + off9);
							wr(a, gpr[dr]);
						end
						OP_STR: wr(gpr[sr1] + off6, gpr[dr]);
						OP_TRAP: begin
							trapped = 1'b1;
							r.trap_vector = inst[7:0];
							if (inst[7:0] == TRAP_HALT) begin
								pc = 16'h0000;
							end else if (inst[7:0] == TRAP_GETC) begin
								gpr[0] = {8'h00, ch};
							end else if (inst[7:0] == TRAP_OUT) begin
								r.out_char = gpr[0][7:0];
								r.out_valid = 1'b1;
							end
						end
						default: ;
					endcase
					if (trapped || (inst == 16'h0000 && rd(pc) == 16'h0000)) begin
						r.step_value = 16'h0000;
					end else begin
						r.step_value = pc;
					end
				end
			endcase
			r.pc_now = pc;
			r.cond_code = cc;
			pending_q.push_back(r);
		endfunction

		// Compare one result transaction with the oldest expectation.
		function void check_result(input step_result_t got);
			step_result_t e;
			if (pending_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (got.step_value !== e.step_value) begin
				$error("step_value: expected %h, got %h", e.step_value, got.step_value);
				errors++;
			end
			if (got.pc_now !== e.pc_now) begin
				$error("pc_now: expected %h, got %h", e.pc_now, got.pc_now);
				errors++;
			end
			if (got.cond_code !== e.cond_code) begin
				$error("cond_code: expected %b, got %b", e.cond_code, got.cond_code);
				errors++;
			end
			if (got.out_char !== e.out_char) begin
				$error("out_char: expected %h, got %h", e.out_char, got.out_char);
				errors++;
			end
			if (got.out_valid !== e.out_valid) begin
				$error("out_valid: expected %b, got %b", e.out_valid, got.out_valid);
				errors++;
			end
			if (got.trap_vector !== e.trap_vector) begin
				$error("trap_vector: expected %h, got %h", e.trap_vector, got.trap_vector);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	lc3_in_if  req ();
	lc3_out_if rsp ();

	step_scoreboard sb = new();
	int             sent = 0;
	int             idle_cycles = 0;
	int             stall_left = 0;
	logic           stalled = 1'b0;

	lc3_instruction_step dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	always #1 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.addr = '0;
		req.data = '0;
		req.reg_index = '0;
		req.char_in = '0;
		rsp.ready = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// Result side: random back-pressure with long runs of readiness.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stalled = ($urandom_range(0, 3) == 0);
			stall_left = stalled ? gap_len() : $urandom_range(1, 30);
		end
		stall_left--;
		rsp.ready <= arst_n && !stalled;
	end

	// Result monitor.
	always @(posedge clk) begin
		step_result_t got;
		if (rsp.valid && rsp.ready) begin
			got.step_value = rsp.step_value;
			got.pc_now = rsp.pc_now;
			got.cond_code = rsp.cond_code;
			got.out_char = rsp.out_char;
			got.out_valid = rsp.out_valid;
			got.trap_vector = rsp.trap_vector;
			sb.check_result(got);
		end
	end

	// Watchdog on cycles without any transaction; allows for the memory clear.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Drive one command, optionally after a gap, and wait until it is taken.
	task automatic send(input logic [1:0] cmd, input logic [15:0] addr,
		input logic [15:0] data, input logic [2:0] ri, input logic [7:0] ch);
		int gap;
		gap = ($urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.addr <= addr;
		req.data <= data;
		req.reg_index <= ri;
		req.char_in <= ch;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_command(cmd, addr, data, ri, ch);
		sent++;
	endtask

	task automatic exec_step();
		send(CMD_EXEC, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
	endtask

	// Lower valid and wait until every expected result has come back.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write start_pc through the configuration port while the core is idle.
	task automatic write_start_pc(input logic [15:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_START_PC;
		pwdata <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.restart_pc = v;
	endtask

	// Random instruction word with the served traps and zero words favored.
	function automatic logic [15:0] random_inst();
		logic [15:0] w;
		w = 16'($urandom);
		case ($urandom_range(0, 9))
			0: w = {OP_TRAP, 4'h0, TRAP_GETC};
			1: w = {OP_TRAP, 4'h0, TRAP_OUT};
			2: w = ($urandom_range(0, 3) == 0) ? {OP_TRAP, 4'h0, TRAP_HALT} : 16'h0000;
			default: ;
		endcase
		return w;
	endfunction

	// Directed program covering every opcode.
	logic [15:0] directed_prog [] = '{
		{OP_ADD, 3'd1, 3'd1, 1'b1, 5'h0F},
		{OP_ADD, 3'd2, 3'd1, 1'b1, 5'h10},
		{OP_AND, 3'd2, 3'd1, 3'b000, 3'd1},
		{OP_NOT, 3'd3, 3'd2, 6'h3F},
		{OP_LEA, 3'd4, 9'h1FF},
		{OP_LD, 3'd5, 9'h100},
		{OP_LDI, 3'd6, 9'h0FF},
		{OP_LDR, 3'd0, 3'd4, 6'h20},
		{OP_ST, 3'd3, 9'h0F0},
		{OP_STI, 3'd1, 9'h0EF},
		{OP_STR, 3'd2, 3'd4, 6'h1F},
		{OP_TRAP, 4'h0, TRAP_GETC},
		{OP_TRAP, 4'h0, TRAP_OUT},
		{OP_TRAP, 4'h0, 8'hFF},
		16'h8FFF,
		16'hD000,
		{OP_BR, 3'b111, 9'h001},
		16'h0000,
		{OP_JSR, 1'b1, 11'h001},
		16'h0000,
		{OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00},
		{OP_JMP, 3'd0, 3'd7, 6'h00},
		{OP_TRAP, 4'h0, TRAP_HALT}
	};

	initial begin
		logic [15:0] base;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset start address, memory extremes included.
		send(CMD_LOAD, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
		send(CMD_WRREG, 16'h0000, 16'h8000, 3'd7, 8'h00);
		drain();
		foreach (directed_prog[i]) begin
			send(CMD_LOAD, START_PC_RESET + 16'(i), directed_prog[i], 3'd0, 8'h00);
		end
		send(CMD_RESTART, 16'h0000, 16'h0000, 3'd0, 8'h00);
		repeat (26) exec_step();

		// Wait until every directed result has come back.
		drain();

		// Random programs at varying restart addresses.
		while (sent < ITEM_GOAL) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_start_pc(16'h0000);
					1: write_start_pc(16'hFFFF);
					default: write_start_pc(16'($urandom));
				endcase
			end
			base = sb.restart_pc;
			n = $urandom_range(3, 12);
			repeat ($urandom_range(0, 3)) begin
				send(CMD_WRREG, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
			end
			for (int i = 0; i < n; i++) begin
				send(CMD_LOAD, base + 16'(i), random_inst(), 3'($urandom), 8'($urandom));
			end
			repeat ($urandom_range(0, 2)) begin
				send(CMD_LOAD, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
			end
			send(CMD_RESTART, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
			repeat (n + $urandom_range(0, 4)) begin
				if ($urandom_range(0, 15) == 0) begin
					send(2'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
						8'($urandom));
				end else begin
					exec_step();
				end
			end
		end

		drain();
		write_start_pc(START_PC_RESET);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/lc3_pkg.sv
rtl/lc3_if.sv
rtl/lc3_mem.sv
rtl/lc3_core.sv
rtl/lc3_instruction_step.sv
bench/tb_lc3_instruction_step.sv
